@@ rtl/core/an2b_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// an2b_pkg: shared types and constants for the ASCII number converter
// Accumulator width, character codes, result kinds and the per-string state.
// ----------------------------------------------------------------------------
package an2b_pkg;

    // Width of the value accumulator (8 to 64, a multiple of four).
    localparam int ACC_BITS = 64;
    localparam int ACC_EXT  = ACC_BITS + 4;
    localparam int CNT_W    = 5;
    localparam int BL_W     = $clog2(ACC_BITS + 1);
    localparam int NIB_W    = $clog2(ACC_BITS / 4 + 1);

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HEX_CHARS = CNT_W'(ACC_BITS / 4);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_OVF   = 2'd3
    } kind_t;

    // State carried from one character of a string to the next.
    typedef struct packed {
        logic [ACC_BITS-1:0] acc;
        logic [CNT_W-1:0]    count;
        logic                bad;
        logic                ovf;
    } str_state_t;

endpackage

@@ rtl/core/an2b_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// an2b_step: one character step of the accumulator
// Classifies a character and folds it into the running value, flagging
// invalid characters and overflow.
// ----------------------------------------------------------------------------
module an2b_step (
    input  an2b_pkg::str_state_t cur,
    input  logic [7:0]           char_code,
    input  logic                 radix_hex,
    output an2b_pkg::str_state_t nxt
);

    logic                         is_dec;
    logic                         is_uc;
    logic                         is_lc;
    logic                         valid;
    logic [3:0]                   digit;
    logic [an2b_pkg::ACC_EXT-1:0] acc_ext;
    logic [an2b_pkg::ACC_EXT-1:0] prod;
    logic                         hex_ovf;
    logic                         dec_ovf;

    assign is_dec = (char_code >= an2b_pkg::CH_0) && (char_code <= an2b_pkg::CH_9);
    assign is_uc  = radix_hex && (char_code >= an2b_pkg::CH_UC_A)
                    && (char_code <= an2b_pkg::CH_UC_F);
    assign is_lc  = radix_hex && (char_code >= an2b_pkg::CH_LC_A)
                    && (char_code <= an2b_pkg::CH_LC_F);
    assign valid  = is_dec || is_uc || is_lc;

    always_comb begin
        priority if (is_dec) begin
            digit = 4'(char_code - an2b_pkg::CH_0);
        end else if (is_uc) begin
            digit = 4'(char_code - an2b_pkg::CH_UC_A + 8'd10);
        end else if (is_lc) begin
            digit = 4'(char_code - an2b_pkg::CH_LC_A + 8'd10);
        end else begin
            digit = 4'd0;
        end
    end

    // Times ten as two shifted copies plus the digit; any carry into the
    // top four bits means the value no longer fits.
    assign acc_ext = {4'b0000, cur.acc};
    assign prod    = (acc_ext << 3) + (acc_ext << 1) + an2b_pkg::ACC_EXT'(digit);
    assign dec_ovf = prod[an2b_pkg::ACC_EXT-1 -: 4] != 4'd0;
    assign hex_ovf = (cur.count >= an2b_pkg::HEX_CHARS)
                     || (cur.acc[an2b_pkg::ACC_BITS-1 -: 4] != 4'd0);

    always_comb begin
        nxt = cur;
        if (!cur.bad && !cur.ovf) begin
            if (!valid) begin
                nxt.bad = 1'b1;
            end else if (radix_hex) begin
                if (hex_ovf) begin
                    nxt.ovf = 1'b1;
                end else begin
                    nxt.acc   = {cur.acc[an2b_pkg::ACC_BITS-5:0], digit};
                    nxt.count = cur.count + 1'b1;
                end
            end else begin
                if (dec_ovf) begin
                    nxt.ovf = 1'b1;
                end else begin
                    nxt.acc = prod[an2b_pkg::ACC_BITS-1:0];
                    if (cur.count != an2b_pkg::CNT_MAX) begin
                        nxt.count = cur.count + 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/core/ascii_number_to_binary_bits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_number_to_binary_bits: ASCII number string to serial binary digits
// Accepts the characters of a decimal or hex number and emits its bits,
// most significant first, or a single status item for special cases.
// ----------------------------------------------------------------------------
// Non-final characters are taken one per cycle. After the final character of
// a data string the accumulator is normalized by the shift register: hex
// strings drop unused nibbles at four bits per cycle, decimal values drop
// leading zeros four or one bit per cycle. Bits then leave one per cycle
// while the receiver accepts them. Reset (aresetn low, synchronous) clears
// the string state, the output register and selects decimal mode.
// ----------------------------------------------------------------------------
module ascii_number_to_binary_bits (
    input  logic       aclk,
    input  logic       aresetn,

    // Configuration: radix_hex, written whenever cfg_we is high.
    input  logic       cfg_we,
    input  logic       cfg_wdata,

    // Input items.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // end_of_string

    // Result items.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] bit_value, [7:1] zero
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // last_result
);

    // ACCUM takes characters, STRIP aligns the value at the top of the
    // shift register, EMIT sends it out one bit per cycle while the output is free.
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_STRIP,
        ST_EMIT
    } state_t;

    state_t                           state_reg;
    logic                             radix_reg;
    an2b_pkg::str_state_t             str_reg;
    an2b_pkg::str_state_t             str_next;
    logic                             hex_out_reg;
    logic [an2b_pkg::BL_W-1:0]        bits_left_reg;
    logic [an2b_pkg::NIB_W-1:0]       skip_reg;
    an2b_pkg::kind_t                  kind_reg;

    logic                             m_tvalid_reg;
    logic                             m_bit_reg;
    an2b_pkg::kind_t                  m_kind_reg;
    logic                             m_last_reg;

    an2b_pkg::kind_t                  final_kind;
    logic                             in_fire;
    logic                             out_free;
    logic                             top_bit;
    logic                             top_nib_zero;

    an2b_step u_step (
        .cur       (str_reg),
        .char_code (s_tdata),
        .radix_hex (radix_reg),
        .nxt       (str_next)
    );

    assign s_tready = (state_reg == ST_ACCUM);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign top_bit      = str_reg.acc[an2b_pkg::ACC_BITS-1];
    assign top_nib_zero = str_reg.acc[an2b_pkg::ACC_BITS-1 -: 4] == 4'd0;

    // What the string turns into once its final character is in. An invalid
    // character wins over overflow; a lone decimal zero is an empty result.
    always_comb begin
        priority if (str_next.bad) begin
            final_kind = an2b_pkg::KIND_BAD;
        end else if (str_next.ovf) begin
            final_kind = an2b_pkg::KIND_OVF;
        end else if (!radix_reg && (str_next.acc == '0)
                     && (str_next.count <= an2b_pkg::CNT_W'(1))) begin
            final_kind = an2b_pkg::KIND_EMPTY;
        end else begin
            final_kind = an2b_pkg::KIND_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            radix_reg     <= 1'b0;
            str_reg       <= '0;
            hex_out_reg   <= 1'b0;
            bits_left_reg <= '0;
            skip_reg      <= '0;
            kind_reg      <= an2b_pkg::KIND_DATA;
            m_tvalid_reg  <= 1'b0;
            m_bit_reg     <= 1'b0;
            m_kind_reg    <= an2b_pkg::KIND_DATA;
            m_last_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end

            // The output register empties when its item is taken, unless the
            // emit step loads the next bit in the same cycle.
            if (m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACCUM: begin
                    if (in_fire) begin
                        if (!s_tlast) begin
                            str_reg <= str_next;
                        end else begin
                            // Final character: the count and flags are spent
                            // here, the accumulator becomes the shift register.
                            str_reg.count <= '0;
                            str_reg.bad   <= 1'b0;
                            str_reg.ovf   <= 1'b0;
                            kind_reg      <= final_kind;
                            hex_out_reg   <= radix_reg;
                            if (final_kind != an2b_pkg::KIND_DATA) begin
                                str_reg.acc   <= '0;
                                bits_left_reg <= an2b_pkg::BL_W'(1);
                                skip_reg      <= '0;
                                state_reg     <= ST_EMIT;
                            end else begin
                                str_reg.acc <= str_next.acc;
                                if (radix_reg) begin
                                    bits_left_reg <= an2b_pkg::BL_W'({str_next.count, 2'b00});
                                    skip_reg      <= an2b_pkg::NIB_W'(an2b_pkg::HEX_CHARS
                                                                      - str_next.count);
                                end else begin
                                    bits_left_reg <= an2b_pkg::BL_W'(an2b_pkg::ACC_BITS);
                                    skip_reg      <= '0;
                                end
                                state_reg <= ST_STRIP;
                            end
                        end
                    end
                end

                ST_STRIP: begin
                    if (hex_out_reg) begin
                        // Drop the nibbles above the characters received.
                        if (skip_reg != '0) begin
                            str_reg.acc <= str_reg.acc << 4;
                            skip_reg    <= skip_reg - 1'b1;
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end else begin
                        // Drop leading zeros, keeping at least one bit.
                        if (!top_bit && (bits_left_reg > an2b_pkg::BL_W'(1))) begin
                            if (top_nib_zero && (bits_left_reg > an2b_pkg::BL_W'(4))) begin
                                str_reg.acc   <= str_reg.acc << 4;
                                bits_left_reg <= bits_left_reg - an2b_pkg::BL_W'(4);
                            end else begin
                                str_reg.acc   <= str_reg.acc << 1;
                                bits_left_reg <= bits_left_reg - an2b_pkg::BL_W'(1);
                            end
                        end else begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        m_bit_reg     <= (kind_reg == an2b_pkg::KIND_DATA) ? top_bit : 1'b0;
                        m_kind_reg    <= kind_reg;
                        m_last_reg    <= (bits_left_reg == an2b_pkg::BL_W'(1));
                        bits_left_reg <= bits_left_reg - an2b_pkg::BL_W'(1);
                        if (bits_left_reg == an2b_pkg::BL_W'(1)) begin
                            str_reg.acc <= '0;
                            state_reg   <= ST_ACCUM;
                        end else begin
                            str_reg.acc <= str_reg.acc << 1;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, m_bit_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/core/an2b_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// an2b_checker: port-level checks for the ASCII number converter
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module an2b_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled item holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Status items stand alone and close their string.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != an2b_pkg::KIND_DATA) |-> m_tlast)
        else $error("status item without last");

    // Status items carry a zero bit.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != an2b_pkg::KIND_DATA) |-> !m_tdata[0])
        else $error("status item with nonzero bit");

    // A status item never follows a data bit of the same string.
    a_no_mixed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid || (m_tuser == an2b_pkg::KIND_DATA))
        else $error("status item inside a bit sequence");

    // Padding bits stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:1] == 7'd0)
        else $error("padding bits not zero");

endmodule

bind ascii_number_to_binary_bits an2b_checker u_an2b_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/ascii_number_to_binary_bits_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_number_to_binary_bits_test: testbench for the ASCII number converter
// Sends decimal and hex number strings, a character per item, and checks
// every output bit and status item against an in-bench model of the
// conversion. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module ascii_number_to_binary_bits_test;

    import an2b_pkg::*;

    // Cycles to let pass once every expected result has arrived. This covers
    // the normalize pass of the shift register plus some margin.
    localparam int DRAIN_CYCLES = ACC_BITS / 4 + 24;
    localparam int GAP_MAX      = 14;
    // Length of the long receiver hold-off that backs the block up.
    localparam int LONG_HOLD    = 300;

    // One result item as the block should present it.
    typedef struct packed {
        logic  bit_value;
        kind_t kind;
        logic  last_result;
    } bit_item_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_code
    logic       s_tlast;   // end_of_string
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] bit_value, [7:1] zero
    logic [1:0] m_tuser;   // [1:0] kind
    logic       m_tlast;   // last_result

    // Bench copy of the converter state, advanced on every accepted item.
    logic                radix_hex_q;
    logic [ACC_BITS-1:0] value_acc;
    logic [CNT_W-1:0]    valid_chars;
    logic                saw_bad;
    logic                saw_ovf;

    bit_item_t  pending_bits[$];
    logic [7:0] char_buf[$];

    int send_gap_max;
    int recv_gap_max;
    bit stall_request;
    int chars_sent;
    int mismatch_count;

    ascii_number_to_binary_bits DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Conversion model
    // ------------------------------------------------------------------------

    // Value of one character as a digit of the given radix, or -1.
    function automatic int digit_value(logic [7:0] c, logic hex);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (hex && c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        if (hex && c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        return -1;
    endfunction

    function automatic void push_bit(logic b, kind_t k, logic l);
        bit_item_t item;
        item.bit_value   = b;
        item.kind        = k;
        item.last_result = l;
        pending_bits.push_back(item);
    endfunction

    // Advances the model by one character and, on the final character of a
    // string, queues every result item that the string produces.
    function automatic void convert_char(logic [7:0] c, logic eos);
        int                  d;
        int                  top;
        int                  nbits;
        logic [ACC_BITS-1:0] dv;
        d = digit_value(c, radix_hex_q);
        dv = ACC_BITS'(d < 0 ? 0 : d);
        // Once a string is marked bad or overflowed, later characters are
        // ignored until its end.
        if (!saw_bad && !saw_ovf) begin
            if (d < 0) begin
                saw_bad = 1'b1;
            end else if (radix_hex_q) begin
                if (valid_chars >= HEX_CHARS || value_acc[ACC_BITS-1 -: 4] != 4'd0) begin
                    saw_ovf = 1'b1;
                end else begin
                    value_acc = {value_acc[ACC_BITS-5:0], dv[3:0]};
                    valid_chars++;
                end
            end else begin
                if (value_acc > ({ACC_BITS{1'b1}} - dv) / 10) begin
                    saw_ovf = 1'b1;
                end else begin
                    value_acc = value_acc * 10 + dv;
                    if (valid_chars != CNT_MAX) valid_chars++;
                end
            end
        end
        if (!eos) return;

        // A bad character wins over overflow.
        if (saw_bad) begin
            push_bit(1'b0, KIND_BAD, 1'b1);
        end else if (saw_ovf) begin
            push_bit(1'b0, KIND_OVF, 1'b1);
        end else if (radix_hex_q) begin
            // Hex keeps leading zeros: four bits per character.
            nbits = int'(valid_chars) * 4;
            for (int i = nbits - 1; i >= 0; i--) begin
                push_bit(value_acc[i], KIND_DATA, i == 0);
            end
        end else if (value_acc == '0) begin
            // A lone zero is an empty result; a longer run of zeros is one 0 bit.
            if (valid_chars <= 1) push_bit(1'b0, KIND_EMPTY, 1'b1);
            else push_bit(1'b0, KIND_DATA, 1'b1);
        end else begin
            top = ACC_BITS - 1;
            while (top > 0 && !value_acc[top]) top--;
            for (int i = top; i >= 0; i--) begin
                push_bit(value_acc[i], KIND_DATA, i == 0);
            end
        end
        value_acc   = '0;
        valid_chars = '0;
        saw_bad     = 1'b0;
        saw_ovf     = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one character after a random gap and waits for the handshake.
    // With no gap, tvalid stays high from the previous item.
    task automatic send_char(logic [7:0] c, logic eos);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        convert_char(c, eos);
        chars_sent++;
    endtask

    // Sends the characters in char_buf as one string, the last one marked.
    task automatic send_buf();
        foreach (char_buf[i]) send_char(char_buf[i], i == char_buf.size() - 1);
        char_buf.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) char_buf.push_back(s[i]);
        send_buf();
    endtask

    // Drops tvalid, waits until every queued result has come out, then lets
    // the block settle.
    task automatic wait_until_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_bits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the radix register while the block is idle.
    task automatic set_radix(logic hex);
        wait_until_idle();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hex;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        radix_hex_q = hex;
    endtask

    // Builds and sends one string for the current radix. Most strings are
    // well formed; some are too long and some carry a random byte.
    task automatic send_random_string();
        logic [63:0] v;
        logic [3:0]  nib;
        int          width;
        int          n;
        int          pick;
        pick = $urandom_range(0, 9);
        if (!radix_hex_q) begin
            if (pick == 0) begin
                // More digits than the accumulator can hold.
                n = $urandom_range(21, 26);
                char_buf.push_back(CH_0 + 8'($urandom_range(1, 9)));
                repeat (n - 1) char_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end else begin
                width = $urandom_range(1, ACC_BITS);
                v = {$urandom, $urandom};
                if (width < 64) v = v & ((64'd1 << width) - 64'd1);
                if (pick == 1) v = '0;
                do begin
                    char_buf.push_front(CH_0 + 8'(v % 10));
                    v = v / 10;
                end while (v != 0);
                if (pick < 3) repeat ($urandom_range(1, 4)) char_buf.push_front(CH_0);
            end
        end else begin
            n = (pick == 0) ? $urandom_range(17, 20) : $urandom_range(1, int'(HEX_CHARS));
            repeat (n) begin
                nib = 4'($urandom);
                if (nib < 10) char_buf.push_back(CH_0 + 8'(nib));
                else if ($urandom_range(0, 1)) char_buf.push_back(CH_UC_A + 8'(nib - 10));
                else char_buf.push_back(CH_LC_A + 8'(nib - 10));
            end
        end
        // Noise: overwrite one character with an arbitrary byte.
        if (pick >= 8) begin
            char_buf[$urandom_range(0, char_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        send_buf();
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    task automatic check_bit_item();
        bit_item_t want;
        if (pending_bits.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result item, actual data=%h kind=%0d last=%b",
                     $time, m_tdata, m_tuser, m_tlast);
            return;
        end
        want = pending_bits.pop_front();
        if (m_tdata !== {7'b0, want.bit_value}) begin
            mismatch_count++;
            $display("%0t: data mismatch, expected %h actual %h",
                     $time, {7'b0, want.bit_value}, m_tdata);
        end
        if (m_tuser !== want.kind) begin
            mismatch_count++;
            $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, m_tuser);
        end
        if (m_tlast !== want.last_result) begin
            mismatch_count++;
            $display("%0t: last mismatch, expected %b actual %b",
                     $time, want.last_result, m_tlast);
        end
    endtask

    // Receiver: draws a stall for every result item, or takes one long
    // hold-off when a test asks for it, then checks the item it accepts.
    initial begin : result_monitor
        int gap;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (stall_request) begin
                gap = LONG_HOLD;
                stall_request = 1'b0;
            end
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_bit_item();
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Decimal special cases: lone zero, zero run, a small value, and bad
    // characters at either end of the byte range and mid-string.
    task automatic test_decimal_cases();
        set_radix(1'b0);
        send_text("0");
        send_text("00");
        send_text("9");
        send_text("5/3");
        send_text("A");
        char_buf.push_back(8'h00);
        send_buf();
        char_buf.push_back(CH_0 + 8'd7);
        char_buf.push_back(8'hFF);
        send_buf();
    endtask

    // Hex: zero keeps its four bits, both letter cases, and letters past F.
    task automatic test_hex_cases();
        set_radix(1'b1);
        send_text("0");
        send_text("F");
        send_text("a");
        send_text("fA");
        send_text("G");
        send_text("g");
        char_buf.push_back(8'h80);
        send_buf();
    endtask

    // Largest values that fit, a full-width hex zero, and the first ones that do not.
    task automatic test_range_limits();
        set_radix(1'b1);
        send_text("FFFFFFFFFFFFFFFF");
        send_text("0000000000000000");
        send_text("10000000000000000");
        set_radix(1'b0);
        send_text("18446744073709551615");
        send_text("18446744073709551616");
    endtask

    // The receiver holds off for a long time while full-width hex strings
    // keep coming, so the block must stall its input.
    task automatic test_backpressure();
        set_radix(1'b1);
        send_gap_max  = 0;
        stall_request = 1'b1;
        repeat (4) send_text("FEDCBA9876543210");
        send_gap_max  = GAP_MAX;
    endtask

    // Random strings in phases that alternate the radix; every third phase
    // runs both sides without idling.
    task automatic test_random_strings();
        int start;
        for (int phase = 0; phase < 5; phase++) begin
            set_radix(phase[0]);
            send_gap_max = (phase % 3 == 2) ? 0 : GAP_MAX;
            recv_gap_max = (phase % 3 == 2) ? 0 : GAP_MAX;
            start = chars_sent;
            while (chars_sent - start < 30) send_random_string();
        end
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        radix_hex_q    = 1'b0;
        value_acc      = '0;
        valid_chars    = '0;
        saw_bad        = 1'b0;
        saw_ovf        = 1'b0;
        send_gap_max   = GAP_MAX;
        recv_gap_max   = GAP_MAX;
        stall_request  = 1'b0;
        chars_sent     = 0;
        mismatch_count = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_decimal_cases();
        test_hex_cases();
        test_range_limits();
        test_backpressure();
        test_random_strings();
        wait_until_idle();

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
